>>> rtl/usbcf_pkg.sv
package usbcf_pkg;

    localparam int unsigned ADDR_W = 4;

    localparam logic [7:0]  TYPE_INTERFACE = 8'd4;
    localparam logic [7:0]  TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0]  MIN_IFACE_LEN  = 8'd9;
    localparam logic [7:0]  MIN_EP_LEN     = 8'd7;
    localparam logic [1:0]  XFER_BULK      = 2'd2;
    localparam int unsigned DIR_IN_BIT     = 7;

    localparam logic [7:0]  CLASS_RST      = 8'h08;
    localparam logic [7:0]  SUBCLASS_RST   = 8'h06;
    localparam logic [7:0]  PROTOCOL_RST   = 8'h50;
    localparam logic [15:0] MAX_PKT_RST    = 16'd512;

    typedef enum logic [1:0] {
        REG_CLASS    = 2'd0,
        REG_SUBCLASS = 2'd1,
        REG_PROTOCOL = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] desc_byte;
        logic       last_byte;
    } desc_word_t;

    typedef struct packed {
        logic        interface_found;
        logic [7:0]  interface_number;
        logic [7:0]  bulk_in_address;
        logic [7:0]  bulk_out_address;
        logic [15:0] bulk_in_max_packet;
        logic        usable;
        logic        stopped_early;
    } res_word_t;

endpackage

>>> rtl/usb_config_descriptor_endpoint_finder_unit.sv
// usb configuration descriptor endpoint finder
// desc channel: one descriptor byte per word (desc_valid / desc_stall), with
//   last_byte marking the final byte of the configuration descriptor
// res channel: one result word per descriptor, issued for the word that
//   carries last_byte (res_valid / res_stall)
// apb port: wanted class, subclass and protocol at byte addresses 0, 4, 8
// each accepted byte updates the walk state in the same cycle; the result
//   appears in the output register in the cycle after the last byte is taken
// throughput is one byte per cycle while desc_stall is low, set by the single
//   state update between the byte input and the result register
// while res_stall holds a waiting result, desc_stall is raised and the
//   result word holds steady; bytes flow again once it is taken
// reset: match registers return to mass storage / scsi / bulk-only, walk
//   state clears, held max packet size returns to 512, no result pending
// after each last byte the walk state clears, max packet size is kept
module usb_config_descriptor_endpoint_finder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         desc_valid,
    output logic                         desc_stall,
    input  usbcf_pkg::desc_word_t        desc_word,
    output logic                         res_valid,
    input  logic                         res_stall,
    output usbcf_pkg::res_word_t         res_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [usbcf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [7:0]  class_reg, subclass_reg, protocol_reg;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic        stopped_reg, stopped_next;
    logic        armed_reg, armed_next;
    logic [31:0] cap_reg, cap_next;
    logic [7:0]  ifnum_reg, ifnum_next;
    logic [7:0]  in_addr_reg, in_addr_next;
    logic [7:0]  out_addr_reg, out_addr_next;
    logic [15:0] max_pkt_reg, max_pkt_next;
    logic        res_valid_reg, res_valid_next;
    usbcf_pkg::res_word_t res_word_reg, res_word_next;

    logic                accept;
    logic                cfg_wr;
    usbcf_pkg::reg_idx_t cfg_idx;

    assign accept     = desc_valid && !desc_stall;
    assign desc_stall = res_valid_reg && res_stall;
    assign res_valid  = res_valid_reg;
    assign res_word   = res_word_reg;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign cfg_idx    = usbcf_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        prdata = 32'd0;
        case (cfg_idx)
            usbcf_pkg::REG_CLASS:    prdata = {24'd0, class_reg};
            usbcf_pkg::REG_SUBCLASS: prdata = {24'd0, subclass_reg};
            usbcf_pkg::REG_PROTOCOL: prdata = {24'd0, protocol_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg    <= usbcf_pkg::CLASS_RST;
            subclass_reg <= usbcf_pkg::SUBCLASS_RST;
            protocol_reg <= usbcf_pkg::PROTOCOL_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                usbcf_pkg::REG_CLASS:    class_reg    <= pwdata[7:0];
                usbcf_pkg::REG_SUBCLASS: subclass_reg <= pwdata[7:0];
                usbcf_pkg::REG_PROTOCOL: protocol_reg <= pwdata[7:0];
                default:                 ;
            endcase
        end
    end

    // byte walk and descriptor apply
    always_comb
    begin
        logic [7:0] b;
        logic       slot_en;
        logic [1:0] slot_idx;
        logic       done;

        b        = desc_word.desc_byte;
        slot_en  = 1'b0;
        slot_idx = 2'd0;
        done     = 1'b0;

        pos_next      = pos_reg;
        len_next      = len_reg;
        type_next     = type_reg;
        stopped_next  = stopped_reg;
        armed_next    = armed_reg;
        cap_next      = cap_reg;
        ifnum_next    = ifnum_reg;
        in_addr_next  = in_addr_reg;
        out_addr_next = out_addr_reg;
        max_pkt_next  = max_pkt_reg;
        res_word_next = res_word_reg;

        if (accept && !stopped_reg)
        begin
            if (pos_reg == 8'd0)
            begin
                if (b == 8'd0)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    len_next  = b;
                    type_next = 8'd0;
                    cap_next  = 32'd0;
                end
            end
            else if (pos_reg == 8'd1)
            begin
                type_next = b;
            end
            else
            begin
                if (type_reg == usbcf_pkg::TYPE_INTERFACE)
                begin
                    if (pos_reg == 8'd2)
                    begin
                        slot_en  = 1'b1;
                        slot_idx = 2'd0;
                    end
                    else if (pos_reg >= 8'd5 && pos_reg <= 8'd7)
                    begin
                        slot_en  = 1'b1;
                        slot_idx = 2'(pos_reg - 8'd4);
                    end
                end
                else if (pos_reg <= 8'd5)
                begin
                    slot_en  = 1'b1;
                    slot_idx = 2'(pos_reg - 8'd2);
                end
                if (slot_en)
                begin
                    cap_next[8*slot_idx +: 8] = b;
                end
            end

            if (!(pos_reg == 8'd0 && b == 8'd0))
            begin
                done = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_next};
                if (done)
                begin
                    pos_next = 8'd0;
                    if (type_next == usbcf_pkg::TYPE_INTERFACE &&
                        len_next >= usbcf_pkg::MIN_IFACE_LEN)
                    begin
                        if (cap_next[15:8] == class_reg &&
                            cap_next[23:16] == subclass_reg &&
                            cap_next[31:24] == protocol_reg)
                        begin
                            armed_next = 1'b1;
                            ifnum_next = cap_next[7:0];
                        end
                        else
                        begin
                            armed_next = 1'b0;
                        end
                    end
                    else if (type_next == usbcf_pkg::TYPE_ENDPOINT && armed_reg &&
                             len_next >= usbcf_pkg::MIN_EP_LEN)
                    begin
                        if (cap_next[9:8] == usbcf_pkg::XFER_BULK)
                        begin
                            if (cap_next[usbcf_pkg::DIR_IN_BIT])
                            begin
                                in_addr_next = cap_next[7:0];
                                max_pkt_next = cap_next[31:16];
                            end
                            else
                            begin
                                out_addr_next = cap_next[7:0];
                            end
                        end
                    end
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
        end

        if (accept && desc_word.last_byte)
        begin
            res_word_next.interface_found    = armed_next;
            res_word_next.interface_number   = ifnum_next;
            res_word_next.bulk_in_address    = in_addr_next;
            res_word_next.bulk_out_address   = out_addr_next;
            res_word_next.bulk_in_max_packet = max_pkt_next;
            res_word_next.usable             = armed_next && (in_addr_next != 8'd0) &&
                                               (out_addr_next != 8'd0);
            res_word_next.stopped_early      = stopped_next;

            pos_next      = 8'd0;
            len_next      = 8'd0;
            type_next     = 8'd0;
            stopped_next  = 1'b0;
            armed_next    = 1'b0;
            cap_next      = 32'd0;
            ifnum_next    = 8'd0;
            in_addr_next  = 8'd0;
            out_addr_next = 8'd0;
        end
    end

    always_comb
    begin
        if (accept && desc_word.last_byte)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 8'd0;
            len_reg       <= 8'd0;
            type_reg      <= 8'd0;
            stopped_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            cap_reg       <= 32'd0;
            ifnum_reg     <= 8'd0;
            in_addr_reg   <= 8'd0;
            out_addr_reg  <= 8'd0;
            max_pkt_reg   <= usbcf_pkg::MAX_PKT_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            type_reg      <= type_next;
            stopped_reg   <= stopped_next;
            armed_reg     <= armed_next;
            cap_reg       <= cap_next;
            ifnum_reg     <= ifnum_next;
            in_addr_reg   <= in_addr_next;
            out_addr_reg  <= out_addr_next;
            max_pkt_reg   <= max_pkt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

endmodule

>>> rtl/usbcf_checker.sv
module usbcf_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  desc_valid,
    input logic                  desc_stall,
    input usbcf_pkg::desc_word_t desc_word,
    input logic                  res_valid,
    input logic                  res_stall,
    input usbcf_pkg::res_word_t  res_word
);

    // a held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // a new result only follows a taken last byte
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(desc_valid && !desc_stall && desc_word.last_byte))
        else $error("result without a last byte");

    a_usable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.usable |-> res_word.interface_found &&
            res_word.bulk_in_address != 8'd0 && res_word.bulk_out_address != 8'd0)
        else $error("usable without interface and both endpoints");

    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_word.bulk_in_address == 8'd0 ||
            res_word.bulk_in_address[7]) && !res_word.bulk_out_address[7])
        else $error("endpoint direction mismatch");

    // bytes keep flowing while the result side is free
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !desc_stall)
        else $error("input stalled with empty output");

endmodule

bind usb_config_descriptor_endpoint_finder_unit usbcf_checker u_usbcf_checker (.*);
